FILE: src/bera_pkg.sv
// Shared types, constants and helper functions of the bit error rate accumulator.
package bera_pkg;

	localparam int WORD_W    = 8;
	localparam int BPW_W     = 4;
	localparam int CNT_W     = 32;
	localparam int BITS_W    = 36;
	localparam int REM_W     = 37;
	localparam int ERRS_W    = 4;
	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = 5;
	localparam int ENTRY_W   = 3 * CNT_W;

	localparam logic [CNT_W-1:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [CNT_W-1:0] Q_ONE = 32'h8000_0000;

	localparam logic [BPW_W-1:0] BPW_RESET  = 4'd8;
	localparam logic [BPW_W-1:0] BPW_MAX    = 4'd8;
	localparam logic [BPW_W-1:0] BPW_MIN    = 4'd1;
	localparam logic             REG_BPW    = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PREP,
		ST_DIV,
		ST_FINISH
	} bera_state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic prep;
		logic div_step;
		logic finish;
	} bera_cmd_t;

	typedef struct packed {
		logic idx_bad;
		logic out_free;
	} bera_status_t;

	function automatic logic [BPW_W-1:0] eff_width(input logic [BPW_W-1:0] bpw);
		logic [BPW_W-1:0] w;
		priority if (bpw == '0) begin
			w = BPW_MIN;
		end else if (bpw > BPW_MAX) begin
			w = BPW_MAX;
		end else begin
			w = bpw;
		end
		return w;
	endfunction

	function automatic logic [ERRS_W-1:0] count_errs(input logic [WORD_W-1:0] d,
			input logic [BPW_W-1:0] w);
		logic [ERRS_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (i < int'(w)) begin
				n = n + ERRS_W'(d[i]);
			end
		end
		return n;
	endfunction

endpackage

FILE: src/bera_ctrl.sv
// Controller state machine sequencing lookup, division and write-back of one transaction.
module bera_ctrl import bera_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  bera_status_t status,
	output bera_cmd_t    cmd
);

	bera_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.idx_bad ? ST_FINISH : ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/bera_dp.sv
// Datapath: per-point table, error count, restoring divider and output register.
module bera_dp import bera_pkg::*; #(
	parameter int POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bera_cmd_t          cmd,
	output bera_status_t       status,
	input  logic [BPW_W-1:0]   bits_per_word,
	input  logic [WORD_W-1:0]  point_index,
	input  logic [WORD_W-1:0]  sent_word,
	input  logic [WORD_W-1:0]  received_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CNT_W-1:0]   ber_value,
	output logic               index_error
);

	localparam int IDX_W = (POINTS > 1) ? $clog2(POINTS) : 1;

	logic [ENTRY_W-1:0] mem [POINTS];
	logic [POINTS-1:0]  vld_q;
	logic [ENTRY_W-1:0] rd_s1;
	logic               rd_vld_s1;

	logic [IDX_W-1:0]   idx_q;
	logic               idx_bad_q;
	logic [WORD_W-1:0]  diff_q;
	logic [CNT_W-1:0]   err_q;
	logic [CNT_W-1:0]   words_q;
	logic [CNT_W-1:0]   ratio_q;
	logic [BITS_W-1:0]  bits_q;
	logic               big_q;
	logic [REM_W-1:0]   rem_q;
	logic [CNT_W-1:0]   quo_q;

	logic               out_valid_q;
	logic [CNT_W-1:0]   ber_q;
	logic               ierr_q;

	logic               idx_bad;
	logic [IDX_W-1:0]   idx_in;
	logic [BPW_W-1:0]   width;
	logic [CNT_W-1:0]   err_old;
	logic [CNT_W-1:0]   words_old;
	logic [CNT_W-1:0]   ratio_old;
	logic [CNT_W:0]     err_sum;
	logic [CNT_W-1:0]   err_new;
	logic [CNT_W:0]     words_p1;
	logic [BITS_W-1:0]  bits_new;
	logic               rem_ge;
	logic [REM_W-1:0]   rem_sub;
	logic [CNT_W-1:0]   ratio_new;
	logic [CNT_W-1:0]   words_new;

	assign idx_bad = {1'b0, point_index} >= (WORD_W + 1)'(POINTS);
	assign idx_in  = point_index[IDX_W-1:0];
	assign width   = eff_width(bits_per_word);

	assign err_old   = rd_vld_s1 ? rd_s1[3*CNT_W-1:2*CNT_W] : '0;
	assign words_old = rd_vld_s1 ? rd_s1[2*CNT_W-1:CNT_W]   : '0;
	assign ratio_old = rd_vld_s1 ? rd_s1[CNT_W-1:0]         : '0;

	assign err_sum  = {1'b0, err_old} + (CNT_W + 1)'(count_errs(diff_q, width));
	assign err_new  = err_sum[CNT_W] ? SAT32 : err_sum[CNT_W-1:0];
	assign words_p1 = {1'b0, words_old} + (CNT_W + 1)'(1);
	assign bits_new = BITS_W'(words_p1) * BITS_W'(width);

	assign rem_ge  = rem_q >= {1'b0, bits_q};
	assign rem_sub = rem_q - {1'b0, bits_q};

	always_comb begin
		priority if (err_q == '0) begin
			ratio_new = ratio_q;
		end else if (big_q || (quo_q > Q_ONE)) begin
			ratio_new = Q_ONE;
		end else begin
			ratio_new = quo_q;
		end
	end

	assign words_new = (words_q == SAT32) ? words_q : words_q + CNT_W'(1);

	assign status.idx_bad  = idx_bad;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.finish && !idx_bad_q) begin
			mem[idx_q] <= {err_q, words_new, ratio_new};
		end
		if (cmd.accept && !idx_bad) begin
			rd_s1 <= mem[idx_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish && !idx_bad_q) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q     <= idx_in;
			idx_bad_q <= idx_bad;
			diff_q    <= sent_word ^ received_word;
			if (!idx_bad) begin
				rd_vld_s1 <= vld_q[idx_in];
			end
		end
		if (cmd.load) begin
			err_q   <= err_new;
			words_q <= words_old;
			ratio_q <= ratio_old;
			bits_q  <= bits_new;
		end
		if (cmd.prep) begin
			big_q <= {(REM_W - CNT_W)'(0), err_q} >= {bits_q, 1'b0};
			rem_q <= REM_W'(err_q);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? {rem_sub[REM_W-2:0], 1'b0} : {rem_q[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[CNT_W-2:0], rem_ge};
		end
		if (cmd.finish) begin
			ber_q  <= idx_bad_q ? '0 : ratio_new;
			ierr_q <= idx_bad_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign ber_value   = ber_q;
	assign index_error = ierr_q;

endmodule

FILE: src/bit_error_rate_accumulator_unit.sv
// Top level of the bit error rate accumulator: register port, controller and datapath.
// Each transaction names a test point, XORs the sent and received words over the low
// bits_per_word bits (0 acts as 1, above 8 as 8), adds the differing bits to the point's
// saturating error total and, when that total is nonzero, stores errors / bits seen as an
// unsigned Q1.31 ratio (saturated at one); the stored ratio is returned and the point's word
// count advances. An in-range transaction occupies the block from acceptance to the next
// possible acceptance: table read, operand setup, a restoring divider producing one quotient
// bit per cycle, and write-back, which waits until the result register is free. An
// out-of-range index goes straight to write-back, is reported with index_error set and
// ber_value zero, frees the input and changes nothing. The per-point table reads as zero
// after reset through one valid flag per point, so no clearing pass is needed. The result
// register lets a new transaction be accepted while the previous result waits.
module bit_error_rate_accumulator_unit import bera_pkg::*; #(
	parameter int POINTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [WORD_W-1:0]   point_index,
	input  logic [WORD_W-1:0]   sent_word,
	input  logic [WORD_W-1:0]   received_word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CNT_W-1:0]    ber_value,
	output logic                index_error
);

	logic [BPW_W-1:0] bpw_q;
	bera_cmd_t        cmd;
	bera_status_t     status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpw_q <= BPW_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BPW)) begin
			bpw_q <= pwdata[BPW_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_BPW) ? 32'(bpw_q) : '0;

	bera_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bera_dp #(
		.POINTS (POINTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.bits_per_word (bpw_q),
		.point_index   (point_index),
		.sent_word     (sent_word),
		.received_word (received_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ber_value     (ber_value),
		.index_error   (index_error)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("input ready while a transaction is in flight");

	a_single_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !cmd.finish)
		else $error("transaction finished twice");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished transaction without result");

	a_index_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && index_error) |-> (ber_value == '0))
		else $error("index error with nonzero ratio");

	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ber_value <= Q_ONE))
		else $error("ratio above one");

endmodule
